// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/evrpm_pkg.sv =====
`default_nettype none

package evrpm_pkg;

    localparam int CNT_W  = 16;
    localparam int TIME_W = 32;
    localparam int CPR_W  = 16;
    localparam int MAG_W  = 32;
    localparam int DEN_W  = CPR_W + TIME_W;
    localparam int ITER_W = $clog2(DEN_W);
    localparam int VEL_W  = 32;
    localparam int STS_W  = 2;

    localparam logic [CNT_W-1:0]  HALF_RANGE = 16'd32768;
    localparam logic [CNT_W-1:0]  RPM_SCALE  = 16'd60000;
    localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd44;
    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(DEN_W - 1);

    typedef enum logic [STS_W-1:0] {
        ST_MEASURED = 2'd0,
        ST_FIRST    = 2'd1,
        ST_ZERO_DT  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [CNT_W-1:0] encoder_count;
        logic [TIME_W-1:0]       time_ms;
    } t_in_word;

    typedef struct packed {
        logic signed [VEL_W-1:0] shaft_rpm;
        logic [STS_W-1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic mul;
        logic prep;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/encoder_velocity_rpm.sv =====
// a word is captured on acceptance, multiplied, given its numerator and divided, then
// loaded into the output register once that is free; division is bypassed (first
// sample, zero interval, zero counts per revolution). A new word is accepted only after
// the result is loaded; a 48-step restoring divider, one quotient bit per cycle
// reset: synchronous active low; counts_per_rev returns to 44, stored sample cleared
`default_nettype none

`include "assert_macros.svh"

module encoder_velocity_rpm
    import evrpm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // sample channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data,
    // counts_per_rev write channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CPR_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // user writes config only while no word is in flight; not enforced, ready held high
    assign o_cfg_ready = 1'b1;

    // sequencer: capture, multiply, numerator setup, divide, hand to output register
    evrpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // wrap of count difference and interval, products, divider and result register
    evrpm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

    // a word is worked on alone: accepting one closes the input
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "input still open after accepting a word")

    // the output register is loaded only when it is free
    `ASSERT_ALWAYS(a_finish_free, !w_cmd.finish || !o_out_valid || i_out_ready,
        "result overwrote a word not yet taken")

    // datapath commands never overlap
    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(w_cmd), "more than one datapath command")

    // bypassed words report zero velocity
    `ASSERT_ALWAYS(a_bypass_zero,
        !o_out_valid || o_out_data.status == ST_MEASURED || o_out_data.shaft_rpm == '0,
        "nonzero velocity with a bypass status")

endmodule

`default_nettype wire

// ===== rtl/evrpm_datapath.sv =====
`default_nettype none

module evrpm_datapath
    import evrpm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in_word         i_in_data,
    input  wire logic             i_cfg_valid,
    input  wire logic [CPR_W-1:0] i_cfg_data,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output t_out_word             o_out_data
);

    // sample state and configuration
    logic [CPR_W-1:0]  r_cpr;
    logic [CNT_W-1:0]  r_last_count;
    logic [TIME_W-1:0] r_last_time;
    logic              r_have;

    // per-word working registers
    t_status           r_code;
    logic              r_neg;
    logic [CNT_W-1:0]  r_abs;
    logic [TIME_W-1:0] r_dt;
    logic [MAG_W-1:0]  r_mag;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    t_out_word         r_out;

    logic [TIME_W-1:0] n_dt;
    logic [CNT_W-1:0]  w_d;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_sub;
    logic [VEL_W-1:0]  w_q;

    assign n_dt    = i_in_data.time_ms - r_last_time;
    assign w_d     = CNT_W'(i_in_data.encoder_count) - r_last_count;
    assign w_trial = {r_rem, r_quo[DEN_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_q     = r_quo[VEL_W-1:0];

    assign o_sts.skip = (r_code != ST_MEASURED) || (r_den == '0);
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr        <= CPR_RESET;
            r_last_count <= '0;
            r_last_time  <= '0;
            r_have       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cpr <= i_cfg_data;
            end
            if (i_cmd.capture && (!r_have || n_dt != '0)) begin
                r_last_count <= CNT_W'(i_in_data.encoder_count);
                r_last_time  <= i_in_data.time_ms;
                r_have       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dt <= n_dt;
            // half range goes positive
            if (w_d > HALF_RANGE) begin
                r_neg <= 1'b1;
                r_abs <= CNT_W'(0) - w_d;
            end else begin
                r_neg <= 1'b0;
                r_abs <= w_d;
            end
            if (!r_have) begin
                r_code <= ST_FIRST;
            end else if (n_dt == '0) begin
                r_code <= ST_ZERO_DT;
            end else begin
                r_code <= ST_MEASURED;
            end
        end
        if (i_cmd.mul) begin
            r_mag <= MAG_W'(r_abs) * MAG_W'(RPM_SCALE);
            r_den <= DEN_W'(r_cpr) * DEN_W'(r_dt);
        end
        if (i_cmd.prep) begin
            // numerator is magnitude plus truncated half divisor
            r_quo <= DEN_W'(r_mag) + (r_den >> 1);
            r_rem <= '0;
        end
        if (i_cmd.step) begin
            if (!w_sub[DEN_W]) begin
                r_rem <= w_sub[DEN_W-1:0];
                r_quo <= {r_quo[DEN_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quo <= {r_quo[DEN_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out.status <= r_code;
            if (o_sts.skip) begin
                r_out.shaft_rpm <= '0;
            end else if (r_neg) begin
                r_out.shaft_rpm <= VEL_W'(0) - w_q;
            end else begin
                r_out.shaft_rpm <= w_q;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/evrpm_ctrl.sv =====
`default_nettype none

module evrpm_ctrl
    import evrpm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [ITER_W-1:0] r_cnt;
    logic [ITER_W-1:0] n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = i_sts.skip ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_cnt       = r_cnt;
        n_out_valid = (r_out_valid && !i_out_ready);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = ITER_LAST;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - ITER_W'(1);
            end
            S_DONE: begin
                o_cmd.finish = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import evrpm_pkg::*;

    // generous bound on run length, covering each word's divide and random idle gaps on both sides
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 100;
    // settling wait after the last drain, longer than the slowest word takes
    localparam int          SETTLE      = 80;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CPR
    } t_row_kind;

    // one row of the directed table
    typedef struct {
        t_row_kind        kind;
        logic [CPR_W-1:0] cpr;
        t_in_word         word;
        bit               typed;
        t_out_word        result;
    } t_row;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_word         in_data;
    logic             out_valid;
    logic             out_ready;
    t_out_word        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CPR_W-1:0] cfg_data;

    encoder_velocity_rpm dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // velocity predictor state, mirrors the block after reset
    logic [CPR_W-1:0]  cpr_now     = CPR_RESET;
    logic [CNT_W-1:0]  held_count  = '0;
    logic [TIME_W-1:0] held_time   = '0;
    bit                have_sample = 1'b0;

    // results still owed by the block, oldest first
    t_out_word rpm_pending[$];

    // last sample sent, so random words can step from it
    logic [CNT_W-1:0]  sent_count = '0;
    logic [TIME_W-1:0] sent_time  = '0;

    // set for stretches where neither side idles
    bit steady = 1'b0;

    int          fails        = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    int          cpr_writes   = 0;
    int unsigned cycles       = 0;
    t_row        dir_rows[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // expected result of one sample word, advances the predictor state
    function automatic t_out_word rpm_predict(input t_in_word w);
        t_out_word         res;
        logic [CNT_W-1:0]  step;
        logic [TIME_W-1:0] dt;
        logic [DEN_W-1:0]  den;
        logic [63:0]       mag;
        logic [63:0]       quo;
        int                diff;
        int                diff_abs;
        res.shaft_rpm = '0;
        // first sample after reset is only stored
        if (!have_sample) begin
            held_count  = w.encoder_count;
            held_time   = w.time_ms;
            have_sample = 1'b1;
            res.status  = ST_FIRST;
            return res;
        end
        dt = w.time_ms - held_time;
        // same time stamp as the stored one: nothing changes
        if (dt == '0) begin
            res.status = ST_ZERO_DT;
            return res;
        end
        // count difference folded into -32767..32768, half range counts as positive
        step = w.encoder_count - held_count;
        diff = $signed({16'd0, step});
        if (step > HALF_RANGE)
            diff = diff - 65536;
        den = DEN_W'(cpr_now) * DEN_W'(dt);
        // zero counts_per_rev gives a zero divisor and a zero velocity
        if (den != '0) begin
            diff_abs = (diff < 0) ? -diff : diff;
            mag = 64'(diff_abs) * 64'd60000;
            // half away from zero with the half divisor truncated
            quo = (mag + 64'(den >> 1)) / 64'(den);
            res.shaft_rpm = (diff < 0) ? -quo[VEL_W-1:0] : quo[VEL_W-1:0];
        end
        held_count = w.encoder_count;
        held_time  = w.time_ms;
        res.status = ST_MEASURED;
        return res;
    endfunction

    // offer one sample word after a random gap, predict once it is taken
    task automatic push_sample(input t_in_word w, input bit typed, input t_out_word fixed);
        int        gap;
        t_out_word want;
        gap = steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        want = rpm_predict(w);
        // table rows with a typed result override the prediction
        if (typed)
            want = fixed;
        rpm_pending.push_back(want);
        sent_count = w.encoder_count;
        sent_time  = w.time_ms;
        samples_sent++;
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rpm_pending.size() != 0)
            @(posedge clk);
    endtask

    // counts_per_rev write, only while the block is idle
    task automatic write_cpr(input logic [CPR_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cpr_now = v;
        cpr_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [CPR_W-1:0] cpr,
                                    input logic [CNT_W-1:0] cnt, input logic [TIME_W-1:0] ms,
                                    input bit typed, input int vel, input t_status sts);
        t_row r;
        r.kind             = kind;
        r.cpr              = cpr;
        r.word.encoder_count = cnt;
        r.word.time_ms     = ms;
        r.typed            = typed;
        r.result.shaft_rpm = vel;
        r.result.status    = sts;
        dir_rows.push_back(r);
    endfunction

    // result side: random stalls, every taken word checked against the oldest owed one
    initial begin
        int        stall;
        t_out_word want;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (rpm_pending.size() == 0) begin
                $error("result word with nothing owed: shaft_rpm %0d status %0d",
                       out_data.shaft_rpm, out_data.status);
                fails++;
            end else begin
                want = rpm_pending.pop_front();
                if (out_data.shaft_rpm !== want.shaft_rpm) begin
                    $error("shaft_rpm expected %0d actual %0d",
                           want.shaft_rpm, out_data.shaft_rpm);
                    fails++;
                end
                if (out_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    fails++;
                end
            end
        end
    end

    // sample side and run control
    initial begin
        t_in_word         w;
        t_out_word        none;
        logic [CNT_W-1:0] delta;
        logic [TIME_W-1:0] dt;
        logic [CPR_W-1:0] cpr;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;

        // directed table, reset value of counts_per_rev (44) at the top
        add_row(ROW_SAMPLE, 0, 16'sd0,      32'd0,          1, 0, ST_FIRST);
        add_row(ROW_SAMPLE, 0, 16'sd0,      32'd0,          1, 0, ST_ZERO_DT);
        add_row(ROW_SAMPLE, 0, 16'sd44,     32'd1000,       0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd44,     32'd1000,       1, 0, ST_ZERO_DT);
        add_row(ROW_SAMPLE, 0, -16'sd44,    32'd2000,       0, 0, ST_MEASURED);
        add_row(ROW_CPR,    1, 0,           0,              0, 0, ST_MEASURED);
        // half range forward, half range backward (taken as forward), largest reverse
        add_row(ROW_SAMPLE, 0, 16'sd32724,  32'd2001,       1, 1966080000, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, -16'sd44,    32'd2002,       1, 1966080000, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd32725,  32'd2003,       1, -1966020000, ST_MEASURED);
        // count and time extremes, time wraps to a one ms interval
        add_row(ROW_SAMPLE, 0, 16'sh7FFF,   32'hFFFF_FFFF,  0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sh8000,   32'd0,          1, 60000, ST_MEASURED);
        add_row(ROW_CPR,    16'hFFFF, 0,    0,              0, 0, ST_MEASURED);
        // widest divisor
        add_row(ROW_SAMPLE, 0, 16'sh8001,   32'hFFFF_FFFF,  0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd0,      32'h8000_0000,  0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd0,      32'h8000_0001,  1, 0, ST_MEASURED);
        // quotient exactly on the half, both signs
        add_row(ROW_CPR,    60000, 0,       0,              0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd1,      32'h8000_0003,  0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd0,      32'h8000_0005,  0, 0, ST_MEASURED);
        // zero counts_per_rev still stores the sample
        add_row(ROW_CPR,    0, 0,           0,              0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd100,    32'h8000_0006,  1, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd200,    32'h8000_0006,  1, 0, ST_ZERO_DT);
        add_row(ROW_CPR,    CPR_RESET, 0,   0,              0, 0, ST_MEASURED);
        add_row(ROW_SAMPLE, 0, 16'sd300,    32'h8000_0007,  0, 0, ST_MEASURED);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CPR) begin
                drain();
                write_cpr(dir_rows[i].cpr);
            end else begin
                push_sample(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
            end
        end

        // random phases, each under its own counts_per_rev
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       cpr = 16'd1;
                1:       cpr = 16'hFFFF;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       cpr = 16'd0;
                        1:       cpr = CPR_RESET;
                        2, 3:    cpr = CPR_W'($urandom_range(1, 16'hFFFF));
                        default: cpr = CPR_W'($urandom_range(1, 64));
                    endcase
                end
            endcase
            write_cpr(cpr);
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                case ($urandom_range(0, 9))
                    0:       delta = CNT_W'($urandom);
                    1:       delta = HALF_RANGE + CNT_W'($urandom_range(0, 2)) - 1'b1;
                    default: delta = CNT_W'($urandom_range(0, 400)) - 16'd200;
                endcase
                case ($urandom_range(0, 15))
                    0:       dt = '0;
                    1:       dt = $urandom;
                    2:       dt = $urandom_range(1, 1 << 20);
                    default: dt = $urandom_range(1, 20);
                endcase
                w.encoder_count = sent_count + delta;
                w.time_ms       = sent_time + dt;
                push_sample(w, 1'b0, none);
                // now and then hold off until the block has caught up
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("%0d samples sent, %0d results checked, %0d counts_per_rev writes",
                 samples_sent, results_seen, cpr_writes);
        $display("covered first sample, zero interval, half range, wrap and zero divisor");
        if (fails == 0 && rpm_pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/evrpm_pkg.sv
rtl/evrpm_datapath.sv
rtl/evrpm_ctrl.sv
rtl/encoder_velocity_rpm.sv
dv/testbench.sv
